// ===== rtl/usd_pkg.sv =====
// shared constants, arctangent table and rotator state type for the direction decoder
package usd_pkg;

  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int ANGLE_CODE_BITS_DEF = 16;

  // number of arctangent entries; stages past the table are skipped
  localparam int ATAN_LEN = 24;

  // residual angle width (units of 2^-32 turn) and Q2.30 vector width
  localparam int PHASE_W = 34;
  localparam int XY_W    = 32;
  localparam int OUT_W   = 16;

  localparam logic signed [XY_W-1:0] CORDIC_X0 = 32'sd652032874;

  localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
    32'h20000000, 32'h12e4051e, 32'h09fb385b, 32'h051111d4,
    32'h028b0d43, 32'h0145d7e1, 32'h00a2f61e, 32'h00517c55,
    32'h0028be53, 32'h00145f2f, 32'h000a2f98, 32'h000517cc,
    32'h00028be6, 32'h000145f3, 32'h0000a2f9, 32'h0000517c,
    32'h000028be, 32'h0000145f, 32'h00000a2f, 32'h00000517,
    32'h0000028b, 32'h00000145, 32'h000000a2, 32'h00000051
  };

  typedef struct packed {
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [PHASE_W-1:0] z;
    logic                      neg;
  } rot_t;

endpackage

// ===== rtl/usd_phase_gen.sv =====
// angle codes to folded cordic start states for azimuth and elevation
module usd_phase_gen #(
  parameter int ANGLE_CODE_BITS = usd_pkg::ANGLE_CODE_BITS_DEF
) (
  input  logic          clk,
  input  logic [31:0]   word,
  output usd_pkg::rot_t az_r,
  output usd_pkg::rot_t el_r
);

  localparam int N    = ANGLE_CODE_BITS;
  localparam int REPS = (33 + N - 1) / N;
  localparam int RW   = REPS * N;
  localparam int PW   = usd_pkg::PHASE_W;

  localparam logic signed [PW-1:0] HALF_TURN    = 34'sd2147483648;
  localparam logic signed [PW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [PW-1:0] NEG_QUARTER  = -34'sd1073741824;

  logic [N-1:0]  ac;
  logic [N-1:0]  ec;
  logic [RW-1:0] az_rep;
  logic [RW-1:0] el_rep;
  logic [33:0]   az_sum;
  logic [32:0]   el_sum;
  logic [32:0]   az_rnd_r;
  logic [32:0]   az_rnd_nxt;
  logic [31:0]   el_rnd_r;
  logic [31:0]   el_rnd_nxt;
  logic signed [PW-1:0] az_ph;
  logic signed [PW-1:0] el_ph;
  usd_pkg::rot_t az_nxt;
  usd_pkg::rot_t el_nxt;

  function automatic usd_pkg::rot_t fold(input logic signed [PW-1:0] p);
    usd_pkg::rot_t r;
    r.x = usd_pkg::CORDIC_X0;
    r.y = '0;
    priority if (p > QUARTER_TURN) begin
      r.z   = p - HALF_TURN;
      r.neg = 1'b1;
    end else if (p < NEG_QUARTER) begin
      r.z   = p + HALF_TURN;
      r.neg = 1'b1;
    end else begin
      r.z   = p;
      r.neg = 1'b0;
    end
    return r;
  endfunction

  assign ac = word[31 -: N];
  assign ec = word[15 -: N];

  // code / (2^N - 1) is the code repeated as a binary fraction
  assign az_rep     = {REPS{ac}};
  assign el_rep     = {REPS{ec}};
  assign az_sum     = {1'b0, az_rep[RW-1 -: 33]} + 34'd1;
  assign el_sum     = {1'b0, el_rep[RW-1 -: 32]} + 33'd1;
  assign az_rnd_nxt = az_sum[33:1];
  assign el_rnd_nxt = el_sum[32:1];

  assign az_ph  = $signed({1'b0, az_rnd_r}) - HALF_TURN;
  assign el_ph  = $signed({2'b00, el_rnd_r}) - QUARTER_TURN;
  assign az_nxt = fold(az_ph);
  assign el_nxt = fold(el_ph);

  always_ff @(posedge clk) begin
    az_rnd_r <= az_rnd_nxt;
    el_rnd_r <= el_rnd_nxt;
    az_r     <= az_nxt;
    el_r     <= el_nxt;
  end

endmodule

// ===== rtl/usd_cordic_cell.sv =====
// one rotation-mode cordic micro-rotation with its pipeline register
module usd_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  usd_pkg::rot_t d_in,
  output usd_pkg::rot_t q_r
);

  localparam int PW = usd_pkg::PHASE_W;
  localparam int XW = usd_pkg::XY_W;
  localparam logic signed [PW-1:0] ATAN = $signed({2'b00, usd_pkg::ATAN_TURNS[STAGE]});

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  usd_pkg::rot_t q_nxt;

  assign dx = $signed(d_in.y) >>> STAGE;
  assign dy = $signed(d_in.x) >>> STAGE;

  always_comb begin
    q_nxt.neg = d_in.neg;
    if (!d_in.z[PW-1]) begin
      q_nxt.x = d_in.x - dx;
      q_nxt.y = d_in.y + dy;
      q_nxt.z = d_in.z - ATAN;
    end else begin
      q_nxt.x = d_in.x + dx;
      q_nxt.y = d_in.y - dy;
      q_nxt.z = d_in.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

// ===== rtl/usd_out_stage.sv =====
// sign fix, component products, rounding and q1.14 saturation
module usd_out_stage (
  input  logic                              clk,
  input  usd_pkg::rot_t                     az,
  input  usd_pkg::rot_t                     el,
  output logic signed [usd_pkg::OUT_W-1:0] dir_x_r,
  output logic signed [usd_pkg::OUT_W-1:0] dir_y_r,
  output logic signed [usd_pkg::OUT_W-1:0] dir_z_r
);

  localparam int XW = usd_pkg::XY_W;
  localparam int OW = usd_pkg::OUT_W;

  localparam logic signed [63:0] Q14_ONE  = 64'sd16384;
  localparam logic signed [63:0] RND_PROD = 64'sd35184372088832;
  localparam logic signed [63:0] RND_SIN  = 64'sd32768;

  logic signed [XW-1:0] ca_r;
  logic signed [XW-1:0] sa_r;
  logic signed [XW-1:0] ce_r;
  logic signed [XW-1:0] se_r;
  logic signed [XW-1:0] se2_r;
  logic signed [63:0]   px_r;
  logic signed [63:0]   pz_r;
  logic signed [63:0]   rx;
  logic signed [63:0]   rz;
  logic signed [63:0]   ry;

  function automatic logic signed [OW-1:0] sat_q14(input logic signed [63:0] v);
    priority if (v > Q14_ONE) begin
      return Q14_ONE[OW-1:0];
    end else if (v < -Q14_ONE) begin
      return -Q14_ONE[OW-1:0];
    end else begin
      return v[OW-1:0];
    end
  endfunction

  assign rx = (px_r + RND_PROD) >>> 46;
  assign rz = (pz_r + RND_PROD) >>> 46;
  assign ry = (64'(se2_r) + RND_SIN) >>> 16;

  always_ff @(posedge clk) begin
    // folded angles come back negated
    ca_r    <= az.neg ? -az.x : az.x;
    sa_r    <= az.neg ? -az.y : az.y;
    ce_r    <= el.neg ? -el.x : el.x;
    se_r    <= el.neg ? -el.y : el.y;
    px_r    <= 64'(ca_r) * 64'(ce_r);
    pz_r    <= 64'(sa_r) * 64'(ce_r);
    se2_r   <= se_r;
    dir_x_r <= sat_q14(rx);
    dir_y_r <= sat_q14(ry);
    dir_z_r <= sat_q14(rz);
  end

endmodule

// ===== rtl/unpack_spherical_direction.sv =====
// packed azimuth/elevation word to q1.14 unit direction vector
//
//  channel   ports                                      handshake
//  input     in_packed_direction[31:0]                  start && !busy
//  result    out_dir_x, out_dir_y, out_dir_z [15:0] s   out_valid strobe, one cycle
//
// one item per clock; each result passes the phase registers (rounded code, folded start state),
// one cell per cordic stage up to ATAN_LEN, then the sign-fix, product and output registers.
// busy stays low, since the cell rows move every clock and nothing waits on the receiver.
// reset clears only the valid line; data registers carry no reset.
module unpack_spherical_direction #(
  parameter int CORDIC_STAGES   = usd_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_CODE_BITS = usd_pkg::ANGLE_CODE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [31:0]                       in_packed_direction,
  output logic                              out_valid,
  output logic signed [usd_pkg::OUT_W-1:0] out_dir_x,
  output logic signed [usd_pkg::OUT_W-1:0] out_dir_y,
  output logic signed [usd_pkg::OUT_W-1:0] out_dir_z
);

  localparam int NSTG = (CORDIC_STAGES < usd_pkg::ATAN_LEN) ? CORDIC_STAGES
                                                             : usd_pkg::ATAN_LEN;
  localparam int LAT  = NSTG + 5;

  usd_pkg::rot_t az_chain [NSTG+1];
  usd_pkg::rot_t el_chain [NSTG+1];
  logic [LAT-1:0] valid_r;
  logic [LAT-1:0] valid_nxt;

  assign busy      = 1'b0;
  assign valid_nxt = {valid_r[LAT-2:0], start & ~busy};
  assign out_valid = valid_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  usd_phase_gen #(
    .ANGLE_CODE_BITS(ANGLE_CODE_BITS)
  ) u_phase (
    .clk  (clk),
    .word (in_packed_direction),
    .az_r (az_chain[0]),
    .el_r (el_chain[0])
  );

  for (genvar g = 0; g < NSTG; g++) begin : g_cell
    usd_cordic_cell #(.STAGE(g)) u_az_cell (
      .clk  (clk),
      .d_in (az_chain[g]),
      .q_r  (az_chain[g+1])
    );
    usd_cordic_cell #(.STAGE(g)) u_el_cell (
      .clk  (clk),
      .d_in (el_chain[g]),
      .q_r  (el_chain[g+1])
    );
  end

  usd_out_stage u_out (
    .clk     (clk),
    .az      (az_chain[NSTG]),
    .el      (el_chain[NSTG]),
    .dir_x_r (out_dir_x),
    .dir_y_r (out_dir_y),
    .dir_z_r (out_dir_z)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted item did not come out after the pipeline latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without an accepted item");

  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dir_x <= 16'sd16384 && out_dir_x >= -16'sd16384))
    else $error("x component outside saturation range");

  a_yz_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dir_y <= 16'sd16384 && out_dir_y >= -16'sd16384 &&
                   out_dir_z <= 16'sd16384 && out_dir_z >= -16'sd16384))
    else $error("y or z component outside saturation range");
`endif

endmodule

// ===== test/tb_unpack_spherical_direction.sv =====
// self-checking regression for the packed spherical direction decoder
module tb_unpack_spherical_direction;
  import usd_pkg::*;

  localparam int  STAGES     = CORDIC_STAGES_DEF;
  localparam int  CODE_BITS  = ANGLE_CODE_BITS_DEF;
  localparam int  LATENCY    = STAGES + 5;
  localparam int  CLK_HALF   = 2;
  localparam int  GAP_PCT    = 31;
  localparam longint QUARTER = 64'sd1073741824;
  localparam longint HALF    = 64'sd2147483648;
  localparam longint Q14_MAX = 64'sd16384;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } dir_vec_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic [31:0]             in_packed_direction = '0;
  logic                    busy;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_dir_x;
  logic signed [OUT_W-1:0] out_dir_y;
  logic signed [OUT_W-1:0] out_dir_z;

  dir_vec_t pending_dirs[$];
  int       mismatches = 0;
  int       items_sent = 0;
  int       dirs_checked = 0;
  bit       gaps_on = 1'b1;

  unpack_spherical_direction #(
    .CORDIC_STAGES  (STAGES),
    .ANGLE_CODE_BITS(CODE_BITS)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_packed_direction(in_packed_direction),
    .out_valid          (out_valid),
    .out_dir_x          (out_dir_x),
    .out_dir_y          (out_dir_y),
    .out_dir_z          (out_dir_z)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #2000000;
    $display("unpack_spherical_direction regression: fail");
    $finish;
  end

  // rotation-mode cordic on a phase in units of 2^-32 turn, results in q2.30
  function automatic void rotate_phase(input longint phase, output longint sn,
                                       output longint cs);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit     flip;
    x = longint'(CORDIC_X0);
    y = 0;
    z = phase;
    flip = 1'b0;
    // fold the outer half turn onto the inner one and negate afterwards
    if (z > QUARTER) begin
      z = z - HALF;
      flip = 1'b1;
    end else if (z < -QUARTER) begin
      z = z + HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TURNS[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TURNS[i]);
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_q14(input longint v);
    if (v > Q14_MAX) begin
      return OUT_W'(Q14_MAX);
    end
    if (v < -Q14_MAX) begin
      return OUT_W'(-Q14_MAX);
    end
    return OUT_W'(v);
  endfunction

  function automatic dir_vec_t decode_direction(input logic [31:0] word);
    longint unsigned maxc;
    longint unsigned az_code;
    longint unsigned el_code;
    longint          az_phase;
    longint          el_phase;
    longint          sa;
    longint          ca;
    longint          se;
    longint          ce;
    dir_vec_t        v;
    maxc = (64'd1 << CODE_BITS) - 1;
    az_code = longint'(word[31:16]) >> (16 - CODE_BITS);
    el_code = longint'(word[15:0]) >> (16 - CODE_BITS);
    az_phase = longint'((((az_code << 33) / maxc) + 1) >> 1) - HALF;
    el_phase = longint'((((el_code << 32) / maxc) + 1) >> 1) - QUARTER;
    rotate_phase(az_phase, sa, ca);
    rotate_phase(el_phase, se, ce);
    v.x = clamp_q14((ca * ce + (64'sd1 <<< 45)) >>> 46);
    v.z = clamp_q14((sa * ce + (64'sd1 <<< 45)) >>> 46);
    v.y = clamp_q14((se + (64'sd1 <<< 15)) >>> 16);
    return v;
  endfunction

  // check each result against the oldest prediction, then record any new item
  always @(posedge clk) begin
    dir_vec_t want;
    if (rst_n && out_valid) begin
      if (pending_dirs.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                 out_dir_x, out_dir_y, out_dir_z);
        mismatches++;
      end else begin
        want = pending_dirs.pop_front();
        dirs_checked++;
        if (out_dir_x !== want.x) begin
          $display("%0t: dir_x expected %0d actual %0d", $time, want.x, out_dir_x);
          mismatches++;
        end
        if (out_dir_y !== want.y) begin
          $display("%0t: dir_y expected %0d actual %0d", $time, want.y, out_dir_y);
          mismatches++;
        end
        if (out_dir_z !== want.z) begin
          $display("%0t: dir_z expected %0d actual %0d", $time, want.z, out_dir_z);
          mismatches++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      pending_dirs.push_back(decode_direction(in_packed_direction));
    end
  end

  // leaves start high at the accepting edge so a following item follows directly
  task automatic send_direction(input logic [31:0] word);
    while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_packed_direction <= word;
    do begin
      @(posedge clk);
    end while (busy);
    items_sent++;
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_dirs.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'(16'h4000 + $urandom_range(0, 3) - 2);
      3:       return 16'(16'hc000 + $urandom_range(0, 3) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_code_extremes();
    logic [15:0] corner [6] = '{16'h0000, 16'hffff, 16'h8000, 16'h7fff,
                                16'h0001, 16'hfffe};
    foreach (corner[i]) begin
      send_direction({corner[i], corner[(i + 1) % 6]});
    end
    send_direction(32'h0000_0000);
    send_direction(32'hffff_ffff);
    // azimuth code at maximum must land on the same vector as code zero
    send_direction(32'hffff_8000);
    send_direction(32'h0000_8000);
    send_direction(32'haaaa_5555);
    send_direction(32'h5555_aaaa);
  endtask

  // azimuth phases right around the quarter-turn fold points
  task automatic test_fold_boundaries();
    send_direction(32'h3fff_8000);
    send_direction(32'h4000_8000);
    send_direction(32'h4001_4000);
    send_direction(32'hbfff_8000);
    send_direction(32'hc000_8000);
    send_direction(32'hc001_c000);
  endtask

  task automatic test_random_directions(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_direction({pick_code(), pick_code()});
      end else begin
        send_direction($urandom);
      end
    end
  endtask

  task automatic test_back_to_back(input int n);
    gaps_on = 1'b0;
    test_random_directions(n);
    gaps_on = 1'b1;
  endtask

  task automatic test_drain_then_burst();
    wait_all_results();
    repeat (LATENCY) @(posedge clk);
    test_random_directions(40);
    wait_all_results();
  endtask

  initial begin
    int spin;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_code_extremes();
    test_fold_boundaries();
    test_random_directions(500);
    test_back_to_back(300);
    test_drain_then_burst();
    test_random_directions(460);

    start <= 1'b0;
    spin = 0;
    while (pending_dirs.size() != 0 && spin < 20 * LATENCY) begin
      @(posedge clk);
      spin++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (pending_dirs.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_dirs.size());
      mismatches++;
    end

    $display("covered %0d packed words (code corners, fold edges, random, bursts)",
             items_sent);
    $display("checked %0d direction vectors, %0d mismatches", dirs_checked, mismatches);
    if (mismatches == 0) begin
      $display("unpack_spherical_direction regression: pass");
    end else begin
      $display("unpack_spherical_direction regression: fail");
    end
    $finish;
  end

endmodule
